// File: sv/lcps_pkg.sv
// Shared types, constants and arithmetic helpers for the tone curve pixel scaler.
package lcps_pkg;

  localparam int CHAN_W      = 8;
  localparam int CURVE_DEPTH = 256;
  localparam int SUM_W       = 10;
  localparam int MUL_W       = 20;
  localparam int PROD_W      = 16;
  localparam int RECIP_THIRD = 683;
  localparam int RECIP_SHIFT = 11;

  localparam int MID_DEPTH = 4;
  localparam int MID_AW    = 2;
  localparam int MID_CW    = 3;
  localparam int OUT_DEPTH = 8;
  localparam int OUT_AW    = 3;
  localparam int OUT_CW    = 4;

  localparam int DIV_STAGES     = 4;
  localparam int STEPS_PER_STG  = 2;
  localparam int NUM_LANES      = 3;
  localparam int INFLIGHT_W     = 4;

  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;
  localparam logic [CHAN_W-1:0] CHAN_ONE = 8'h01;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] curve_index;
    logic [CHAN_W-1:0] curve_value;
  } in_beat_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] intensity;
    logic [CHAN_W-1:0] divisor;
  } pix_job_t;

  typedef struct packed {
    logic     push;
    pix_job_t job;
  } job_push_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pix_res_t;

  typedef struct packed {
    logic              sat;
    logic [CHAN_W-1:0] rem;
    logic [CHAN_W-1:0] low;
    logic [CHAN_W-1:0] quo;
  } div_lane_t;

  typedef struct packed {
    logic [CHAN_W-1:0]               divisor;
    div_lane_t [NUM_LANES-1:0]       lane;
  } div_stage_t;

  function automatic div_lane_t lane_init(logic [PROD_W-1:0] p, logic [CHAN_W-1:0] d);
    div_lane_t l;
    l.sat = (p[PROD_W-1:CHAN_W] >= d);
    l.rem = p[PROD_W-1:CHAN_W];
    l.low = p[CHAN_W-1:0];
    l.quo = '0;
    return l;
  endfunction

  function automatic div_lane_t div_step(div_lane_t l, logic [CHAN_W-1:0] d);
    logic [CHAN_W:0] t;
    logic            ge;
    div_lane_t       n;
    t     = {l.rem, l.low[CHAN_W-1]};
    ge    = (t >= {1'b0, d});
    n     = l;
    n.rem = ge ? CHAN_W'(t - {1'b0, d}) : t[CHAN_W-1:0];
    n.low = {l.low[CHAN_W-2:0], 1'b0};
    n.quo = {l.quo[CHAN_W-2:0], ge};
    return n;
  endfunction

  function automatic logic [CHAN_W-1:0] lane_result(div_lane_t l);
    return l.sat ? CHAN_MAX : l.quo;
  endfunction

endpackage

// File: sv/lcps_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lcps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: sv/lcps_front.sv
// Front end: accepts beats, computes intensity, owns the curve table and looks up divisors.
module lcps_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  input  lcps_pkg::in_beat_t          in_beat,
  output logic                        in_full,
  input  logic [lcps_pkg::MID_CW-1:0] mid_count,
  output lcps_pkg::job_push_t         mid_push
);

  logic                          a_vld_r, a_vld_nxt;
  lcps_pkg::in_beat_t            a_beat_r, a_beat_nxt;
  logic                          b_vld_r, b_vld_nxt;
  logic [lcps_pkg::CHAN_W-1:0]   b_red_r, b_red_nxt;
  logic [lcps_pkg::CHAN_W-1:0]   b_green_r, b_green_nxt;
  logic [lcps_pkg::CHAN_W-1:0]   b_blue_r, b_blue_nxt;
  logic [lcps_pkg::CHAN_W-1:0]   b_int_r, b_int_nxt;
  logic                          b_tab_vld_r, b_tab_vld_nxt;
  logic [lcps_pkg::CURVE_DEPTH-1:0] tab_vld_r, tab_vld_nxt;

  logic                          accept;
  logic [lcps_pkg::SUM_W-1:0]    sum;
  logic [lcps_pkg::MUL_W-1:0]    scaled;
  logic [lcps_pkg::CHAN_W-1:0]   intensity;
  logic                          tab_we;
  logic [lcps_pkg::CHAN_W-1:0]   tab_wdata;
  logic [lcps_pkg::CHAN_W-1:0]   tab_rdata;
  logic [lcps_pkg::MID_CW:0]     reserved;

  assign reserved = (lcps_pkg::MID_CW+1)'(mid_count) + (lcps_pkg::MID_CW+1)'(a_vld_r)
                  + (lcps_pkg::MID_CW+1)'(b_vld_r);
  assign in_full  = (reserved >= (lcps_pkg::MID_CW+1)'(lcps_pkg::MID_DEPTH));
  assign accept   = in_push && !in_full;

  // Intensity is the channel sum divided by three through a fixed reciprocal.
  assign sum       = {2'b00, a_beat_r.red} + {2'b00, a_beat_r.green} + {2'b00, a_beat_r.blue};
  assign scaled    = {{(lcps_pkg::MUL_W-lcps_pkg::SUM_W){1'b0}}, sum}
                   * lcps_pkg::MUL_W'(lcps_pkg::RECIP_THIRD);
  assign intensity = scaled[lcps_pkg::RECIP_SHIFT+lcps_pkg::CHAN_W-1:lcps_pkg::RECIP_SHIFT];

  assign tab_we    = a_vld_r && (a_beat_r.kind == lcps_pkg::KIND_WRITE);
  assign tab_wdata = (a_beat_r.curve_value == '0) ? lcps_pkg::CHAN_ONE : a_beat_r.curve_value;

  lcps_ram #(
    .WIDTH(lcps_pkg::CHAN_W),
    .DEPTH(lcps_pkg::CURVE_DEPTH)
  ) u_curve (
    .clk  (clk),
    .we   (tab_we),
    .waddr(a_beat_r.curve_index),
    .wdata(tab_wdata),
    .raddr(intensity),
    .rdata(tab_rdata)
  );

  always_comb begin
    a_vld_nxt  = accept;
    a_beat_nxt = accept ? in_beat : a_beat_r;

    tab_vld_nxt = tab_vld_r;
    if (tab_we) begin
      tab_vld_nxt[a_beat_r.curve_index] = 1'b1;
    end

    b_vld_nxt     = a_vld_r && (a_beat_r.kind == lcps_pkg::KIND_PIXEL);
    b_red_nxt     = a_beat_r.red;
    b_green_nxt   = a_beat_r.green;
    b_blue_nxt    = a_beat_r.blue;
    b_int_nxt     = intensity;
    b_tab_vld_nxt = tab_vld_r[intensity];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r   <= 1'b0;
      b_vld_r   <= 1'b0;
      tab_vld_r <= '0;
    end else begin
      a_vld_r   <= a_vld_nxt;
      b_vld_r   <= b_vld_nxt;
      tab_vld_r <= tab_vld_nxt;
    end
    a_beat_r    <= a_beat_nxt;
    b_red_r     <= b_red_nxt;
    b_green_r   <= b_green_nxt;
    b_blue_r    <= b_blue_nxt;
    b_int_r     <= b_int_nxt;
    b_tab_vld_r <= b_tab_vld_nxt;
  end

  // An entry never written has its valid bit clear, and the intensity itself is then used as the divisor.
  // Black pixels divide zero by one so that the back end needs no special case.
  always_comb begin
    mid_push.push          = b_vld_r;
    mid_push.job.red       = b_red_r;
    mid_push.job.green     = b_green_r;
    mid_push.job.blue      = b_blue_r;
    mid_push.job.intensity = b_int_r;
    if (b_int_r == '0) begin
      mid_push.job.divisor = lcps_pkg::CHAN_ONE;
    end else if (b_tab_vld_r) begin
      mid_push.job.divisor = tab_rdata;
    end else begin
      mid_push.job.divisor = b_int_r;
    end
  end

endmodule

// File: sv/lcps_mid_queue.sv
// Short job queue that decouples the front end from the divider back end.
module lcps_mid_queue (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lcps_pkg::job_push_t         push,
  input  logic                        pop,
  output lcps_pkg::pix_job_t          head,
  output logic                        empty,
  output logic [lcps_pkg::MID_CW-1:0] count
);

  lcps_pkg::pix_job_t          mem_r [lcps_pkg::MID_DEPTH];
  logic [lcps_pkg::MID_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [lcps_pkg::MID_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [lcps_pkg::MID_CW-1:0] count_r, count_nxt;
  logic                        do_pop;

  assign empty  = (count_r == '0);
  assign do_pop = pop && !empty;
  assign head   = mem_r[rd_ptr_r];
  assign count  = count_r;

  always_comb begin
    wr_ptr_nxt = push.push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + lcps_pkg::MID_CW'(push.push) - lcps_pkg::MID_CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push.push) begin
      mem_r[wr_ptr_r] <= push.job;
    end
  end

endmodule

// File: sv/lcps_back.sv
// Back end: multiplies, divides in a pipelined restoring divider and queues the results.
module lcps_back (
  input  logic                clk,
  input  logic                rst_n,
  input  lcps_pkg::pix_job_t  q_head,
  input  logic                q_empty,
  output logic                q_pop,
  output lcps_pkg::pix_res_t  res,
  output logic                res_empty,
  input  logic                res_pop
);

  localparam int LAST = lcps_pkg::DIV_STAGES - 1;

  logic                          m_vld_r, m_vld_nxt;
  lcps_pkg::pix_job_t            m_job_r, m_job_nxt;
  logic                          p_vld_r, p_vld_nxt;
  logic [lcps_pkg::PROD_W-1:0]   p_prod_r [lcps_pkg::NUM_LANES];
  logic [lcps_pkg::PROD_W-1:0]   p_prod_nxt [lcps_pkg::NUM_LANES];
  logic [lcps_pkg::CHAN_W-1:0]   p_div_r, p_div_nxt;
  logic [lcps_pkg::DIV_STAGES-1:0] s_vld_r, s_vld_nxt;
  lcps_pkg::div_stage_t          s_r [lcps_pkg::DIV_STAGES];
  lcps_pkg::div_stage_t          s_nxt [lcps_pkg::DIV_STAGES];

  lcps_pkg::pix_res_t            mem_r [lcps_pkg::OUT_DEPTH];
  logic [lcps_pkg::OUT_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [lcps_pkg::OUT_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [lcps_pkg::OUT_CW-1:0]   count_r, count_nxt;

  logic [lcps_pkg::INFLIGHT_W-1:0] inflight;
  logic [lcps_pkg::OUT_CW:0]       committed;
  logic                            res_push;
  logic                            do_res_pop;
  lcps_pkg::pix_res_t              res_new;
  lcps_pkg::pix_job_t              mj;

  // A job leaves the queue only when the result queue has room for everything in flight.
  assign inflight  = lcps_pkg::INFLIGHT_W'($countones({m_vld_r, p_vld_r, s_vld_r}));
  assign committed = (lcps_pkg::OUT_CW+1)'(count_r) + (lcps_pkg::OUT_CW+1)'(inflight);
  assign q_pop     = !q_empty && (committed < (lcps_pkg::OUT_CW+1)'(lcps_pkg::OUT_DEPTH));

  assign mj = m_job_r;

  always_comb begin
    m_vld_nxt = q_pop;
    m_job_nxt = q_pop ? q_head : m_job_r;

    p_vld_nxt     = m_vld_r;
    p_div_nxt     = mj.divisor;
    p_prod_nxt[0] = {8'd0, mj.red}   * {8'd0, mj.intensity};
    p_prod_nxt[1] = {8'd0, mj.green} * {8'd0, mj.intensity};
    p_prod_nxt[2] = {8'd0, mj.blue}  * {8'd0, mj.intensity};
  end

  always_comb begin
    lcps_pkg::div_stage_t cur;
    for (int k = 0; k < lcps_pkg::DIV_STAGES; k++) begin
      if (k == 0) begin
        cur.divisor = p_div_r;
        for (int c = 0; c < lcps_pkg::NUM_LANES; c++) begin
          cur.lane[c] = lcps_pkg::lane_init(p_prod_r[c], p_div_r);
        end
        s_vld_nxt[k] = p_vld_r;
      end else begin
        cur          = s_r[k-1];
        s_vld_nxt[k] = s_vld_r[k-1];
      end
      for (int j = 0; j < lcps_pkg::STEPS_PER_STG; j++) begin
        for (int c = 0; c < lcps_pkg::NUM_LANES; c++) begin
          cur.lane[c] = lcps_pkg::div_step(cur.lane[c], cur.divisor);
        end
      end
      s_nxt[k] = cur;
    end
  end

  assign res_push      = s_vld_r[LAST];
  assign res_new.red   = lcps_pkg::lane_result(s_r[LAST].lane[0]);
  assign res_new.green = lcps_pkg::lane_result(s_r[LAST].lane[1]);
  assign res_new.blue  = lcps_pkg::lane_result(s_r[LAST].lane[2]);

  assign res_empty  = (count_r == '0);
  assign do_res_pop = res_pop && !res_empty;
  assign res        = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = res_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_res_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + lcps_pkg::OUT_CW'(res_push) - lcps_pkg::OUT_CW'(do_res_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r  <= 1'b0;
      p_vld_r  <= 1'b0;
      s_vld_r  <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      m_vld_r  <= m_vld_nxt;
      p_vld_r  <= p_vld_nxt;
      s_vld_r  <= s_vld_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    m_job_r <= m_job_nxt;
    p_div_r <= p_div_nxt;
    for (int c = 0; c < lcps_pkg::NUM_LANES; c++) begin
      p_prod_r[c] <= p_prod_nxt[c];
    end
    for (int k = 0; k < lcps_pkg::DIV_STAGES; k++) begin
      s_r[k] <= s_nxt[k];
    end
    if (res_push) begin
      mem_r[wr_ptr_r] <= res_new;
    end
  end

endmodule

// File: sv/luminance_curve_pixel_scaler.sv
// Top level of the tone curve pixel scaler.
// The block takes one beat per clock on both sides when nothing stalls. A curve
// write beat takes an input slot like a pixel beat but gives no result; a pixel
// beat gives one result, and results leave in the order their pixels arrived.
// The rate is set by the curve table, which has one write port and one read port
// and serves one lookup or one write per cycle, and by the four-stage divider,
// which starts one pixel per cycle. The curve table comes out of reset as identity
// at once through per-entry valid bits, with no clearing pass. Input stalls (full)
// only when the front queue is backed up by a stalled result side.
module luminance_curve_pixel_scaler (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic                        in_kind,
  input  logic [lcps_pkg::CHAN_W-1:0] in_red_in,
  input  logic [lcps_pkg::CHAN_W-1:0] in_green_in,
  input  logic [lcps_pkg::CHAN_W-1:0] in_blue_in,
  input  logic [lcps_pkg::CHAN_W-1:0] in_curve_index,
  input  logic [lcps_pkg::CHAN_W-1:0] in_curve_value,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic [lcps_pkg::CHAN_W-1:0] out_red_out,
  output logic [lcps_pkg::CHAN_W-1:0] out_green_out,
  output logic [lcps_pkg::CHAN_W-1:0] out_blue_out
);

  lcps_pkg::in_beat_t          beat;
  lcps_pkg::job_push_t         mid_push;
  lcps_pkg::pix_job_t          mid_head;
  logic                        mid_empty;
  logic                        mid_pop;
  logic [lcps_pkg::MID_CW-1:0] mid_count;
  lcps_pkg::pix_res_t          res;

  always_comb begin
    beat.kind        = in_kind;
    beat.red         = in_red_in;
    beat.green       = in_green_in;
    beat.blue        = in_blue_in;
    beat.curve_index = in_curve_index;
    beat.curve_value = in_curve_value;
  end

  lcps_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_beat  (beat),
    .in_full  (in_full),
    .mid_count(mid_count),
    .mid_push (mid_push)
  );

  lcps_mid_queue u_mid (
    .clk  (clk),
    .rst_n(rst_n),
    .push (mid_push),
    .pop  (mid_pop),
    .head (mid_head),
    .empty(mid_empty),
    .count(mid_count)
  );

  lcps_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_head   (mid_head),
    .q_empty  (mid_empty),
    .q_pop    (mid_pop),
    .res      (res),
    .res_empty(out_empty),
    .res_pop  (out_pop)
  );

  assign out_red_out   = res.red;
  assign out_green_out = res.green;
  assign out_blue_out  = res.blue;

endmodule

// File: sv/lcps_checker.sv
// Port-level assertions for the tone curve pixel scaler, bound to the top level.
module lcps_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_push,
  input logic                        in_full,
  input logic                        out_empty,
  input logic                        out_pop,
  input logic [lcps_pkg::CHAN_W-1:0] out_red_out,
  input logic [lcps_pkg::CHAN_W-1:0] out_green_out,
  input logic [lcps_pkg::CHAN_W-1:0] out_blue_out
);

  // Reset leaves no result waiting.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result side not empty after reset");

  // Reset leaves the input side open.
  a_reset_open: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input side full after reset");

  // Backpressure on the input only builds up from a beat taken in the cycle before.
  a_full_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_full) |-> $past(in_push && !in_full))
    else $error("full rose without an accepted beat");

  // A waiting result holds until it is taken.
  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=>
      (!out_empty && $stable(out_red_out) && $stable(out_green_out)
       && $stable(out_blue_out)))
    else $error("waiting result changed before it was taken");

endmodule

bind luminance_curve_pixel_scaler lcps_checker u_lcps_checker (.*);

// File: dv/tb_luminance_curve_pixel_scaler.sv
// Testbench for the tone curve pixel scaler: directed table, random beats, scoreboard check.
module tb_luminance_curve_pixel_scaler;
  import lcps_pkg::*;

  localparam int DIR_ROWS   = 26;
  localparam int RAND_BEATS = 1050;
  localparam bit BY_HAND    = 1'b1;
  localparam bit BY_PRED    = 1'b0;

  typedef enum {POP_ALWAYS, POP_HALF, POP_EVERY4, POP_SPARSE} pop_mode_t;

  typedef struct packed {
    logic              kind;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] curve_index;
    logic [CHAN_W-1:0] curve_value;
    logic              by_hand;
    logic [CHAN_W-1:0] want_red;
    logic [CHAN_W-1:0] want_green;
    logic [CHAN_W-1:0] want_blue;
  } dir_row_t;

  typedef struct {
    in_beat_t beat;
    bit       by_hand;
    pix_res_t want;
  } stim_t;

  logic              clk;
  logic              rst_n;
  logic              in_push;
  logic              in_full;
  logic              in_kind;
  logic [CHAN_W-1:0] in_red_in;
  logic [CHAN_W-1:0] in_green_in;
  logic [CHAN_W-1:0] in_blue_in;
  logic [CHAN_W-1:0] in_curve_index;
  logic [CHAN_W-1:0] in_curve_value;
  logic              out_empty;
  logic              out_pop;
  logic [CHAN_W-1:0] out_red_out;
  logic [CHAN_W-1:0] out_green_out;
  logic [CHAN_W-1:0] out_blue_out;

  logic [CHAN_W-1:0] curve_shadow [CURVE_DEPTH];
  pix_res_t          pending_pixels [$];
  stim_t             stim_q [$];
  int unsigned       error_count;

  dir_row_t dir_table [DIR_ROWS] = '{
    '{KIND_PIXEL, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   BY_HAND, 8'd0,   8'd0,   8'd0},
    '{KIND_PIXEL, 8'd1,   8'd1,   8'd0,   8'd0,   8'd0,   BY_HAND, 8'd0,   8'd0,   8'd0},
    '{KIND_PIXEL, 8'd255, 8'd255, 8'd255, 8'd0,   8'd0,   BY_HAND, 8'd255, 8'd255, 8'd255},
    '{KIND_PIXEL, 8'd255, 8'd0,   8'd0,   8'd0,   8'd0,   BY_HAND, 8'd255, 8'd0,   8'd0},
    '{KIND_PIXEL, 8'd0,   8'd255, 8'd0,   8'd0,   8'd0,   BY_HAND, 8'd0,   8'd255, 8'd0},
    '{KIND_PIXEL, 8'd0,   8'd0,   8'd255, 8'd0,   8'd0,   BY_HAND, 8'd0,   8'd0,   8'd255},
    '{KIND_PIXEL, 8'd1,   8'd1,   8'd1,   8'd0,   8'd0,   BY_HAND, 8'd1,   8'd1,   8'd1},
    '{KIND_PIXEL, 8'd10,  8'd20,  8'd30,  8'd0,   8'd0,   BY_HAND, 8'd10,  8'd20,  8'd30},
    '{KIND_WRITE, 8'd0,   8'd0,   8'd0,   8'd200, 8'd1,   BY_PRED, 8'd0,   8'd0,   8'd0},
    '{KIND_PIXEL, 8'd200, 8'd200, 8'd200, 8'd0,   8'd0,   BY_HAND, 8'd255, 8'd255, 8'd255},
    '{KIND_WRITE, 8'd0,   8'd0,   8'd0,   8'd170, 8'd1,   BY_PRED, 8'd0,   8'd0,   8'd0},
    '{KIND_PIXEL, 8'd0,   8'd255, 8'd255, 8'd0,   8'd0,   BY_HAND, 8'd0,   8'd255, 8'd255},
    '{KIND_WRITE, 8'd0,   8'd0,   8'd0,   8'd100, 8'd255, BY_PRED, 8'd0,   8'd0,   8'd0},
    '{KIND_PIXEL, 8'd100, 8'd100, 8'd100, 8'd0,   8'd0,   BY_HAND, 8'd39,  8'd39,  8'd39},
    '{KIND_WRITE, 8'd0,   8'd0,   8'd0,   8'd50,  8'd0,   BY_PRED, 8'd0,   8'd0,   8'd0},
    '{KIND_PIXEL, 8'd1,   8'd49,  8'd100, 8'd0,   8'd0,   BY_HAND, 8'd50,  8'd255, 8'd255},
    '{KIND_WRITE, 8'd0,   8'd0,   8'd0,   8'd0,   8'd7,   BY_PRED, 8'd0,   8'd0,   8'd0},
    '{KIND_PIXEL, 8'd0,   8'd0,   8'd2,   8'd0,   8'd0,   BY_HAND, 8'd0,   8'd0,   8'd0},
    '{KIND_WRITE, 8'd255, 8'd255, 8'd255, 8'd254, 8'd127, BY_PRED, 8'd0,   8'd0,   8'd0},
    '{KIND_PIXEL, 8'd254, 8'd255, 8'd255, 8'd0,   8'd0,   BY_HAND, 8'd255, 8'd255, 8'd255},
    '{KIND_PIXEL, 8'd3,   8'd3,   8'd3,   8'd3,   8'd1,   BY_HAND, 8'd3,   8'd3,   8'd3},
    '{KIND_WRITE, 8'd0,   8'd0,   8'd0,   8'd7,   8'd2,   BY_PRED, 8'd0,   8'd0,   8'd0},
    '{KIND_PIXEL, 8'd7,   8'd7,   8'd8,   8'd0,   8'd0,   BY_PRED, 8'd0,   8'd0,   8'd0},
    '{KIND_WRITE, 8'd0,   8'd0,   8'd0,   8'd128, 8'd200, BY_PRED, 8'd0,   8'd0,   8'd0},
    '{KIND_PIXEL, 8'd128, 8'd128, 8'd128, 8'd0,   8'd0,   BY_PRED, 8'd0,   8'd0,   8'd0},
    '{KIND_PIXEL, 8'd255, 8'd255, 8'd255, 8'd0,   8'd0,   BY_PRED, 8'd0,   8'd0,   8'd0}
  };

  luminance_curve_pixel_scaler dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_kind        (in_kind),
    .in_red_in      (in_red_in),
    .in_green_in    (in_green_in),
    .in_blue_in     (in_blue_in),
    .in_curve_index (in_curve_index),
    .in_curve_value (in_curve_value),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_red_out    (out_red_out),
    .out_green_out  (out_green_out),
    .out_blue_out   (out_blue_out)
  );

  function automatic logic [CHAN_W-1:0] scaled_channel(logic [CHAN_W-1:0] chan,
                                                       logic [CHAN_W-1:0] lum,
                                                       logic [CHAN_W-1:0] divisor);
    logic [PROD_W-1:0] quo;
    quo = (PROD_W'(chan) * PROD_W'(lum)) / PROD_W'(divisor);
    return (quo > PROD_W'(CHAN_MAX)) ? CHAN_MAX : quo[CHAN_W-1:0];
  endfunction

  function automatic logic [CHAN_W-1:0] random_divisor();
    if ($urandom_range(0, 31) == 0) begin
      return '0;
    end
    if ($urandom_range(0, 2) == 0) begin
      return CHAN_W'($urandom_range(1, 4));
    end
    return CHAN_W'($urandom_range(1, 255));
  endfunction

  function automatic logic [CHAN_W-1:0] extreme_channel();
    case ($urandom_range(0, 3))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd254;
      default: return 8'd255;
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    error_count++;
    $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  task automatic check_channel(string name, logic [CHAN_W-1:0] got, logic [CHAN_W-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    end
  endtask

  task automatic predict_tone(stim_t s);
    pix_res_t          res;
    logic [SUM_W-1:0]  sum;
    logic [CHAN_W-1:0] lum;
    logic [CHAN_W-1:0] divisor;
    if (s.beat.kind == KIND_WRITE) begin
      curve_shadow[s.beat.curve_index] = (s.beat.curve_value == '0) ? CHAN_ONE
                                                                   : s.beat.curve_value;
    end else begin
      sum = SUM_W'(s.beat.red) + SUM_W'(s.beat.green) + SUM_W'(s.beat.blue);
      lum = CHAN_W'(sum / SUM_W'(3));
      res = '0;
      if (lum != '0) begin
        divisor   = curve_shadow[lum];
        res.red   = scaled_channel(s.beat.red, lum, divisor);
        res.green = scaled_channel(s.beat.green, lum, divisor);
        res.blue  = scaled_channel(s.beat.blue, lum, divisor);
      end
      if (s.by_hand) begin
        res = s.want;
      end
      pending_pixels.push_back(res);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #2000000;
    $display("tb_luminance_curve_pixel_scaler: done, errors");
    $finish;
  end

  initial begin
    stim_t       s;
    int unsigned n_rand;
    int unsigned pick;
    int unsigned k;
    int unsigned burst;
    int unsigned gap;
    int unsigned drain;
    logic [CHAN_W-1:0] idx;

    in_push        <= 1'b0;
    in_kind        <= KIND_PIXEL;
    in_red_in      <= '0;
    in_green_in    <= '0;
    in_blue_in     <= '0;
    in_curve_index <= '0;
    in_curve_value <= '0;
    error_count = 0;
    for (int i = 0; i < CURVE_DEPTH; i++) begin
      curve_shadow[i] = CHAN_W'(i);
    end

    foreach (dir_table[i]) begin
      s.beat.kind        = dir_table[i].kind;
      s.beat.red         = dir_table[i].red;
      s.beat.green       = dir_table[i].green;
      s.beat.blue        = dir_table[i].blue;
      s.beat.curve_index = dir_table[i].curve_index;
      s.beat.curve_value = dir_table[i].curve_value;
      s.by_hand          = dir_table[i].by_hand;
      s.want.red         = dir_table[i].want_red;
      s.want.green       = dir_table[i].want_green;
      s.want.blue        = dir_table[i].want_blue;
      stim_q.push_back(s);
    end

    n_rand = 0;
    while (n_rand < RAND_BEATS) begin
      pick               = $urandom_range(0, 99);
      s.by_hand          = BY_PRED;
      s.want             = '0;
      s.beat.kind        = KIND_PIXEL;
      s.beat.red         = CHAN_W'($urandom);
      s.beat.green       = CHAN_W'($urandom);
      s.beat.blue        = CHAN_W'($urandom);
      s.beat.curve_index = CHAN_W'($urandom);
      s.beat.curve_value = CHAN_W'($urandom);
      if (pick < 14) begin
        s.beat.kind        = KIND_WRITE;
        s.beat.curve_value = random_divisor();
      end else if (pick < 30) begin
        idx                = CHAN_W'($urandom_range(1, 255));
        s.beat.kind        = KIND_WRITE;
        s.beat.curve_index = idx;
        s.beat.curve_value = random_divisor();
        stim_q.push_back(s);
        n_rand++;
        s.beat.kind  = KIND_PIXEL;
        s.beat.red   = idx;
        s.beat.green = idx;
        s.beat.blue  = (idx < 8'd254) ? idx + CHAN_W'($urandom_range(0, 2)) : idx;
      end else if (pick < 40) begin
        s.beat.red   = CHAN_W'($urandom_range(0, 2));
        s.beat.green = CHAN_W'($urandom_range(0, 2));
        s.beat.blue  = CHAN_W'($urandom_range(0, 2));
      end else if (pick < 52) begin
        s.beat.red   = extreme_channel();
        s.beat.green = extreme_channel();
        s.beat.blue  = extreme_channel();
      end
      stim_q.push_back(s);
      n_rand++;
    end

    while (rst_n !== 1'b1) @(posedge clk);

    k = 0;
    while (k < stim_q.size()) begin
      burst = $urandom_range(1, 40);
      while (burst > 0 && k < stim_q.size()) begin
        in_push        <= 1'b1;
        in_kind        <= stim_q[k].beat.kind;
        in_red_in      <= stim_q[k].beat.red;
        in_green_in    <= stim_q[k].beat.green;
        in_blue_in     <= stim_q[k].beat.blue;
        in_curve_index <= stim_q[k].beat.curve_index;
        in_curve_value <= stim_q[k].beat.curve_value;
        @(posedge clk);
        while (in_full) @(posedge clk);
        predict_tone(stim_q[k]);
        k++;
        burst--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_push <= 1'b0;

    drain = 0;
    while (pending_pixels.size() != 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    if (pending_pixels.size() != 0) begin
      report_mismatch($sformatf("%0d expected beats never arrived", pending_pixels.size()));
    end
    repeat (30) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_luminance_curve_pixel_scaler: done, clean");
    end else begin
      $display("tb_luminance_curve_pixel_scaler: done, errors");
    end
    $finish;
  end

  initial begin
    pix_res_t    want;
    pop_mode_t   mode;
    int unsigned seg_left;
    int unsigned hold_left;
    int unsigned pops_seen;
    int unsigned tick;
    bit          held;

    out_pop   <= 1'b0;
    mode      = POP_ALWAYS;
    seg_left  = 0;
    hold_left = 0;
    pops_seen = 0;
    tick      = 0;
    held      = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);

    forever begin
      @(posedge clk);
      if (out_pop && !out_empty) begin
        pops_seen++;
        if (pending_pixels.size() == 0) begin
          report_mismatch($sformatf("unexpected result beat %0d/%0d/%0d",
                                    out_red_out, out_green_out, out_blue_out));
        end else begin
          want = pending_pixels.pop_front();
          check_channel("red", out_red_out, want.red);
          check_channel("green", out_green_out, want.green);
          check_channel("blue", out_blue_out, want.blue);
        end
      end
      if (!held && pops_seen >= 300) begin
        held      = 1'b1;
        hold_left = 500;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          mode     = pop_mode_t'($urandom_range(0, 3));
          seg_left = $urandom_range(20, 80);
        end
        seg_left--;
        tick++;
        case (mode)
          POP_ALWAYS: out_pop <= 1'b1;
          POP_HALF:   out_pop <= 1'($urandom_range(0, 1));
          POP_EVERY4: out_pop <= (tick % 4 == 0);
          default:    out_pop <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

endmodule
